@@ hw/rtl/wpd_pkg.sv @@
package wpd_pkg;

    // Output sample resolution; the low 32 - SAMPLE_WIDTH bits are cleared.
    localparam int SAMPLE_WIDTH = 32;
    localparam logic [31:0] SAMPLE_MASK =
        ~((32'd1 << (32 - SAMPLE_WIDTH)) - 32'd1);

    // Chunk and header tags, first file byte in the low byte.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Result kinds.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_ERROR  = 1'b1;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NOT_WAVE   = 2'd1;
    localparam logic [1:0] ERR_INCOMPLETE = 2'd2;
    localparam logic [1:0] ERR_ZERO_FRAME = 2'd3;

    // IEEE single precision format code in the fmt chunk.
    localparam logic [15:0] FMT_FLOAT = 16'd3;

    // Sample depth class of one channel word.
    typedef enum logic [2:0] {
        DEPTH_8,
        DEPTH_16,
        DEPTH_24,
        DEPTH_32,
        DEPTH_OTHER
    } t_depth;

    // One queue word from the parser to the sample back end.
    typedef struct packed {
        logic        is_err;
        logic [1:0]  err_code;
        logic [31:0] raw;
        t_depth      depth;
        logic        is_float;
        logic        first;
        logic        frame_end;
        logic [15:0] chan_count;
    } t_entry;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage

@@ hw/rtl/wpd_fifo.sv @@
module wpd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wpd_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output wpd_pkg::t_entry o_entry,
    output logic            o_empty
);
    import wpd_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr;
    logic [QUEUE_AW-1:0] r_rd;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW+1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

@@ hw/rtl/wpd_front.sv @@
module wpd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic [7:0]      i_file_byte,
    input  logic            i_last_byte,
    output logic            o_push,
    output wpd_pkg::t_entry o_entry
);
    import wpd_pkg::*;

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_HDR,
        PH_BODY,
        PH_DATA,
        PH_DRAIN
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [31:0] r_tag, n_tag;
    logic [32:0] r_rem, n_rem;
    logic        r_fmt, n_fmt;
    logic [15:0] r_afmt, n_afmt;
    logic [15:0] r_chans, n_chans;
    logic        r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic [12:0] r_sbytes, n_sbytes;
    logic [12:0] r_bis, n_bis;
    logic [15:0] r_chidx, n_chidx;

    logic [32:0] w_size;
    logic [32:0] w_padded;
    logic [12:0] w_bis_inc;
    logic        w_fend;
    t_depth      w_dclass;

    // Depth class for channel words.
    always_comb begin
        unique case (r_depth)
            16'd8:   w_dclass = DEPTH_8;
            16'd16:  w_dclass = DEPTH_16;
            16'd24:  w_dclass = DEPTH_24;
            16'd32:  w_dclass = DEPTH_32;
            default: w_dclass = DEPTH_OTHER;
        endcase
    end

    // Byte parser.
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_tag    = r_tag;
        n_rem    = r_rem;
        n_fmt    = r_fmt;
        n_afmt   = r_afmt;
        n_chans  = r_chans;
        n_rate   = r_rate;
        n_depth  = r_depth;
        n_sbytes = r_sbytes;
        n_bis    = r_bis;
        n_chidx  = r_chidx;
        o_push   = 1'b0;
        o_entry            = '0;
        o_entry.depth      = w_dclass;
        o_entry.is_float   = (r_afmt == FMT_FLOAT);
        o_entry.chan_count = r_chans;
        w_size    = '0;
        w_padded  = '0;
        w_bis_inc = r_bis + 13'd1;
        w_fend    = ({1'b0, r_chidx} + 17'd1) >= {1'b0, r_chans};

        unique case (r_phase)
            PH_RIFF, PH_WAVE: begin
                n_tag = {i_file_byte, r_tag[31:8]};
                n_pos = r_pos + 5'd1;
                if (n_pos == 5'd4) begin
                    if (n_tag != ((r_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                        o_push = 1'b1;
                        o_entry.is_err   = 1'b1;
                        o_entry.err_code = ERR_NOT_WAVE;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_phase = (r_phase == PH_RIFF) ? PH_RSIZE : PH_HDR;
                    end
                    n_pos = '0;
                    n_tag = '0;
                end
            end
            PH_RSIZE: begin
                n_pos = r_pos + 5'd1;
                if (n_pos == 5'd4) begin
                    n_pos   = '0;
                    n_phase = PH_WAVE;
                end
            end
            PH_HDR: begin
                if (r_pos < 5'd4) begin
                    n_tag = {i_file_byte, r_tag[31:8]};
                end else begin
                    n_rem = r_rem | ({25'b0, i_file_byte} << {r_pos[1:0], 3'b000});
                end
                n_pos = r_pos + 5'd1;
                if (n_pos == 5'd8) begin
                    w_size   = n_rem;
                    w_padded = w_size + {32'b0, w_size[0]};
                    n_pos    = '0;
                    n_fmt    = 1'b0;
                    if (n_tag == TAG_DATA) begin
                        if (!r_rate || r_chans == '0 || r_depth == '0) begin
                            o_push = 1'b1;
                            o_entry.is_err   = 1'b1;
                            o_entry.err_code = ERR_INCOMPLETE;
                            n_phase = PH_DRAIN;
                        end else if (r_depth[15:3] == '0) begin
                            o_push = 1'b1;
                            o_entry.is_err   = 1'b1;
                            o_entry.err_code = ERR_ZERO_FRAME;
                            n_phase = PH_DRAIN;
                        end else begin
                            n_sbytes = r_depth[15:3];
                            n_bis    = '0;
                            n_chidx  = '0;
                            n_rem    = w_size;
                            n_phase  = (w_size == '0) ? PH_DRAIN : PH_DATA;
                        end
                    end else begin
                        if (n_tag == TAG_FMT) begin
                            if (w_size >= 33'd16) begin
                                n_fmt = 1'b1;
                            end else begin
                                n_afmt  = '0;
                                n_chans = '0;
                                n_rate  = 1'b0;
                                n_depth = '0;
                            end
                        end
                        n_rem   = w_padded;
                        n_phase = (w_padded == '0) ? PH_HDR : PH_BODY;
                        if (w_padded == '0) begin
                            n_fmt = 1'b0;
                        end
                    end
                    n_tag = '0;
                    if (n_phase != PH_BODY && n_phase != PH_DATA) begin
                        n_rem = '0;
                    end
                end
            end
            PH_BODY: begin
                if (r_fmt) begin
                    unique case (r_pos)
                        5'd0:  n_afmt  = {r_afmt[15:8], i_file_byte};
                        5'd1:  n_afmt  = {i_file_byte, r_afmt[7:0]};
                        5'd2:  n_chans = {r_chans[15:8], i_file_byte};
                        5'd3:  n_chans = {i_file_byte, r_chans[7:0]};
                        5'd4:  n_rate  = (i_file_byte != 8'd0);
                        5'd5, 5'd6, 5'd7: n_rate = r_rate || (i_file_byte != 8'd0);
                        5'd14: n_depth = {r_depth[15:8], i_file_byte};
                        5'd15: n_depth = {i_file_byte, r_depth[7:0]};
                        default: ;
                    endcase
                end
                if (r_pos < 5'd16) begin
                    n_pos = r_pos + 5'd1;
                end
                n_rem = r_rem - 33'd1;
                if (n_rem == '0) begin
                    n_phase = PH_HDR;
                    n_pos   = '0;
                    n_fmt   = 1'b0;
                end
            end
            PH_DATA: begin
                if (r_bis[12:2] == '0) begin
                    n_tag = r_tag | ({24'b0, i_file_byte} << {r_bis[1:0], 3'b000});
                end
                n_bis = w_bis_inc;
                n_rem = r_rem - 33'd1;
                if (w_bis_inc >= r_sbytes) begin
                    o_push = 1'b1;
                    o_entry.raw       = n_tag;
                    o_entry.first     = (r_chidx == '0);
                    o_entry.frame_end = w_fend;
                    n_tag   = '0;
                    n_bis   = '0;
                    n_chidx = w_fend ? 16'd0 : r_chidx + 16'd1;
                end
                if (n_rem == '0) begin
                    n_phase = PH_DRAIN;
                end
            end
            default: ;
        endcase

        // End of file: report a truncated header, then rearm.
        if (i_last_byte) begin
            if (!o_push) begin
                if (n_phase == PH_RIFF || n_phase == PH_RSIZE || n_phase == PH_WAVE) begin
                    o_push = 1'b1;
                    o_entry.is_err   = 1'b1;
                    o_entry.err_code = ERR_NOT_WAVE;
                end else if (n_phase == PH_HDR || n_phase == PH_BODY) begin
                    o_push = 1'b1;
                    o_entry.is_err   = 1'b1;
                    o_entry.err_code = ERR_INCOMPLETE;
                end
            end
            n_phase  = PH_RIFF;
            n_pos    = '0;
            n_tag    = '0;
            n_rem    = '0;
            n_fmt    = 1'b0;
            n_afmt   = '0;
            n_chans  = '0;
            n_rate   = 1'b0;
            n_depth  = '0;
            n_sbytes = '0;
            n_bis    = '0;
            n_chidx  = '0;
        end

        if (!i_go) begin
            o_push = 1'b0;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_pos    <= '0;
            r_tag    <= '0;
            r_rem    <= '0;
            r_fmt    <= 1'b0;
            r_afmt   <= '0;
            r_chans  <= '0;
            r_rate   <= 1'b0;
            r_depth  <= '0;
            r_sbytes <= '0;
            r_bis    <= '0;
            r_chidx  <= '0;
        end else if (i_go) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_tag    <= n_tag;
            r_rem    <= n_rem;
            r_fmt    <= n_fmt;
            r_afmt   <= n_afmt;
            r_chans  <= n_chans;
            r_rate   <= n_rate;
            r_depth  <= n_depth;
            r_sbytes <= n_sbytes;
            r_bis    <= n_bis;
            r_chidx  <= n_chidx;
        end
    end

endmodule

@@ hw/rtl/wpd_back.sv @@
module wpd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wpd_pkg::t_entry i_entry,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_result_kind,
    output logic [31:0]     o_sample,
    output logic [1:0]      o_error_code
);
    import wpd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    localparam logic [5:0] DIV_STEPS = 6'd48;

    t_state             r_state;
    logic signed [32:0] r_val;
    logic               r_first;
    logic               r_end;
    logic [15:0]        r_div;
    logic signed [47:0] r_acc;
    logic               r_neg;
    logic [47:0]        r_dvd;
    logic [16:0]        r_rem;
    logic [5:0]         r_step;
    logic               r_out_valid;
    logic               r_kind;
    logic [31:0]        r_sample;
    logic [1:0]         r_err;

    logic               w_out_free;
    logic               w_load_err;
    logic               w_load_smp;
    logic signed [32:0] w_conv;
    logic signed [47:0] w_sum;
    logic [16:0]        w_rem_sh;
    logic               w_qbit;
    logic [47:0]        w_quot;

    // IEEE single to Q0.31, truncating toward zero, saturating at full scale.
    function automatic logic signed [32:0] f_float_q31(input logic [31:0] f);
        logic [7:0]  ex;
        logic [31:0] mag;
        logic signed [32:0] res;
        ex  = f[30:23];
        mag = '0;
        if (ex == 8'hFF && f[22:0] != '0) begin
            res = '0;
        end else if (ex >= 8'd127) begin
            res = f[31] ? 33'sh1_8000_0000 : 33'sh0_7FFF_FFFF;
        end else if (ex == 8'd0) begin
            res = '0;
        end else begin
            if (ex >= 8'd119) begin
                mag = {8'b0, 1'b1, f[22:0]} << (ex - 8'd119);
            end else if ((8'd119 - ex) >= 8'd32) begin
                mag = '0;
            end else begin
                mag = {8'b0, 1'b1, f[22:0]} >> (8'd119 - ex);
            end
            res = f[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        end
        return res;
    endfunction

    // Per-channel conversion to a signed Q0.31 value.
    always_comb begin
        unique case (i_entry.depth)
            DEPTH_8:  w_conv = {~i_entry.raw[7], ~i_entry.raw[7], i_entry.raw[6:0], 24'b0};
            DEPTH_16: w_conv = {i_entry.raw[15], i_entry.raw[15:0], 16'b0};
            DEPTH_24: w_conv = {i_entry.raw[23], i_entry.raw[23:0], 8'b0};
            DEPTH_32: w_conv = i_entry.is_float ? f_float_q31(i_entry.raw)
                                                : {i_entry.raw[31], i_entry.raw};
            default:  w_conv = '0;
        endcase
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_pop = (r_state == S_IDLE) && !i_empty && (!i_entry.is_err || w_out_free);
    assign w_sum = (r_first ? 48'sd0 : r_acc) + 48'(r_val);

    // A result enters the output register from an error word or a finished frame.
    assign w_load_err = o_pop && i_entry.is_err;
    assign w_load_smp = (r_state == S_DONE) && w_out_free;

    // One restoring division step per cycle.
    assign w_rem_sh = {r_rem[15:0], r_dvd[47]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_div});
    assign w_quot   = r_neg ? -r_dvd : r_dvd;

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_sample      = r_sample;
    assign o_error_code  = r_err;

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_err || w_load_smp) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_entry.is_err) begin
                            r_kind      <= KIND_ERROR;
                            r_sample    <= '0;
                            r_err       <= i_entry.err_code;
                        end else begin
                            r_val   <= w_conv;
                            r_first <= i_entry.first;
                            r_end   <= i_entry.frame_end;
                            r_div   <= i_entry.chan_count;
                            r_state <= S_ACC;
                        end
                    end
                end
                S_ACC: begin
                    r_acc   <= w_sum;
                    r_state <= r_end ? S_PREP : S_IDLE;
                end
                S_PREP: begin
                    r_neg   <= r_acc[47];
                    r_dvd   <= r_acc[47] ? 48'(-r_acc) : 48'(r_acc);
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_qbit ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
                    r_dvd  <= {r_dvd[46:0], w_qbit};
                    r_step <= r_step + 6'd1;
                    if (r_step == DIV_STEPS - 6'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_kind      <= KIND_SAMPLE;
                        r_sample    <= w_quot[31:0] & SAMPLE_MASK;
                        r_err       <= ERR_NONE;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_sample_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_SAMPLE |-> r_err == ERR_NONE)
        else $error("sample result carries an error code");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_ERROR |-> r_sample == '0 && r_err != ERR_NONE)
        else $error("error result malformed");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_step < DIV_STEPS && r_div != '0)
        else $error("divider out of range");
`endif

endmodule

@@ hw/rtl/wav_pcm_stream_decoder.sv @@
// WAV decoder with mono Q0.31 output.
// Input channel: one file word per accepted cycle (i_valid high, o_stall low),
// with i_last_byte marking the final word of a file; the parser then rearms.
// Output channel: one result word per accept (o_valid high, i_stall low);
// o_result_kind tells a mono sample from an error report.
// The parser takes one word per cycle and pushes channel words and error
// reports into a four-entry queue; o_stall rises only when that queue is full.
// The back end pops a channel word, converts it and adds it to the frame sum;
// after the last channel of a frame it takes the sum's sign and magnitude,
// divides bit-serially by the channel count and loads the output register,
// and only then pops the next word. An error report is loaded straight from
// the queue into the output register.
// While the receiver stalls, the output register holds its result and the
// back end waits to load the next one; the queue then fills and stalls input.
// Reset (synchronous, active low) empties the queue and output and returns
// the parser to expect a new file header.
module wav_pcm_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [31:0] o_sample,
    output logic [1:0]  o_error_code
);
    import wpd_pkg::*;

    logic   w_full;
    logic   w_go;
    logic   w_push;
    t_entry w_push_entry;
    logic   w_pop;
    t_entry w_head;
    logic   w_empty;

    assign o_stall = w_full;
    assign w_go    = i_valid && !w_full;

    // Parser front end.
    wpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_file_byte (i_file_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .o_entry     (w_push_entry)
    );

    // Decoupling queue.
    wpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_entry (w_head),
        .o_empty (w_empty)
    );

    // Sample conversion, downmix and output register.
    wpd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (o_result_kind),
        .o_sample      (o_sample),
        .o_error_code  (o_error_code)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import wpd_pkg::*;

    // Parser phases of the predictor.
    typedef enum logic [2:0] {
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_HDR, PH_BODY, PH_DATA, PH_DRAIN
    } t_phase;

    typedef struct packed {
        logic [7:0] fbyte;
        logic       last;
    } t_word;

    typedef struct packed {
        logic        kind;
        logic [31:0] smp;
        logic [1:0]  err;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_file_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_result_kind;
    logic [31:0] o_sample;
    logic [1:0]  o_error_code;

    wav_pcm_stream_decoder u_dut (.*);

    // Decoder state mirror.
    t_phase      ph;
    logic [31:0] bpos;
    logic [31:0] tag;
    logic [32:0] remain;
    logic        is_fmt;
    logic [15:0] afmt;
    logic [15:0] nchan;
    logic        rate_nz;
    logic [15:0] depth;
    logic [31:0] sbytes;
    logic [12:0] bis;
    logic [15:0] chidx;
    longint      acc;

    t_word   word_q[$];
    t_result sample_q[$];
    int      errors;
    int      n_samples;
    int      n_reports;
    int      n_files;
    bit      stim_done;
    bit      hold_rx;
    bit      hold_tx;

    task automatic clear_state();
        ph = PH_RIFF; bpos = 0; tag = 0; remain = 0; is_fmt = 0;
        afmt = 0; nchan = 0; rate_nz = 0; depth = 0;
        sbytes = 0; bis = 0; chidx = 0; acc = 0;
    endtask

    function automatic longint float_q31(logic [31:0] f);
        logic [7:0]  ex;
        logic [23:0] man;
        longint      mag;
        ex = f[30:23];
        man = {1'b1, f[22:0]};
        if (ex == 8'hFF && f[22:0] != 0) return 0;
        if (ex >= 127) return f[31] ? -64'sd2147483648 : 64'sd2147483647;
        if (ex == 0) return 0;
        if (ex >= 119) mag = longint'(man) << (ex - 119);
        else if (119 - ex >= 32) mag = 0;
        else mag = longint'(man) >> (119 - ex);
        return f[31] ? -mag : mag;
    endfunction

    function automatic longint chan_q31(logic [31:0] raw);
        case (depth)
            16'd8:  return (longint'(raw[7:0]) - 128) * 16777216;
            16'd16: return longint'($signed(raw[15:0])) * 65536;
            16'd24: return longint'($signed(raw[23:0])) * 256;
            16'd32: begin
                if (afmt == FMT_FLOAT) return float_q31(raw);
                return longint'($signed(raw));
            end
            default: return 0;
        endcase
    endfunction

    // Advance the mirror by one file word; queue any result it causes.
    task automatic decode_word(t_word w);
        t_result r;
        bit      got;
        logic [32:0] size;
        longint  q;
        got = 0;
        r = '0;
        case (ph)
            PH_RIFF, PH_WAVE: begin
                tag = (tag >> 8) | (32'(w.fbyte) << 24);
                bpos++;
                if (bpos == 4) begin
                    if (tag != ((ph == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
                        got = 1; r = '{KIND_ERROR, 32'd0, ERR_NOT_WAVE};
                        ph = PH_DRAIN;
                    end else begin
                        ph = (ph == PH_RIFF) ? PH_RSIZE : PH_HDR;
                    end
                    bpos = 0; tag = 0;
                end
            end
            PH_RSIZE: begin
                bpos++;
                if (bpos == 4) begin
                    bpos = 0; ph = PH_WAVE;
                end
            end
            PH_HDR: begin
                if (bpos < 4) tag = (tag >> 8) | (32'(w.fbyte) << 24);
                else remain = remain | (33'(w.fbyte) << (8 * ((bpos - 4) & 3)));
                bpos++;
                if (bpos == 8) begin
                    size = remain;
                    bpos = 0;
                    is_fmt = 0;
                    if (tag == TAG_DATA) begin
                        if (!rate_nz || nchan == 0 || depth == 0) begin
                            got = 1; r = '{KIND_ERROR, 32'd0, ERR_INCOMPLETE};
                            ph = PH_DRAIN;
                        end else if ((depth >> 3) == 0) begin
                            got = 1; r = '{KIND_ERROR, 32'd0, ERR_ZERO_FRAME};
                            ph = PH_DRAIN;
                        end else begin
                            sbytes = 32'(depth >> 3);
                            bis = 0; chidx = 0; acc = 0;
                            ph = (size == 0) ? PH_DRAIN : PH_DATA;
                        end
                    end else begin
                        if (tag == TAG_FMT) begin
                            if (size >= 16) is_fmt = 1;
                            else begin
                                afmt = 0; nchan = 0; rate_nz = 0; depth = 0;
                            end
                        end
                        remain = size + size[0];
                        ph = (remain == 0) ? PH_HDR : PH_BODY;
                        if (ph == PH_HDR) is_fmt = 0;
                    end
                    tag = 0;
                    if (ph != PH_BODY && ph != PH_DATA) remain = 0;
                end
            end
            PH_BODY: begin
                if (is_fmt) begin
                    case (bpos)
                        0: afmt[7:0] = w.fbyte;
                        1: afmt[15:8] = w.fbyte;
                        2: nchan[7:0] = w.fbyte;
                        3: nchan[15:8] = w.fbyte;
                        4: rate_nz = (w.fbyte != 0);
                        5, 6, 7: rate_nz = rate_nz || (w.fbyte != 0);
                        14: depth[7:0] = w.fbyte;
                        15: depth[15:8] = w.fbyte;
                        default: ;
                    endcase
                end
                if (bpos < 16) bpos++;
                remain--;
                if (remain == 0) begin
                    ph = PH_HDR; bpos = 0; is_fmt = 0;
                end
            end
            PH_DATA: begin
                if (bis < 4) tag = tag | (32'(w.fbyte) << (8 * bis));
                bis = bis + 1;
                remain--;
                if (32'(bis) >= sbytes) begin
                    acc += chan_q31(tag);
                    tag = 0; bis = 0;
                    chidx++;
                    if (chidx >= nchan) begin
                        q = acc / longint'(nchan);
                        got = 1; r = '{KIND_SAMPLE, 32'(q) & SAMPLE_MASK, ERR_NONE};
                        acc = 0; chidx = 0;
                    end
                end
                if (remain == 0) ph = PH_DRAIN;
            end
            default: ;
        endcase
        if (w.last) begin
            if (!got) begin
                if (ph <= PH_WAVE) begin
                    got = 1; r = '{KIND_ERROR, 32'd0, ERR_NOT_WAVE};
                end else if (ph == PH_HDR || ph == PH_BODY) begin
                    got = 1; r = '{KIND_ERROR, 32'd0, ERR_INCOMPLETE};
                end
            end
            clear_state();
        end
        if (got) sample_q.push_back(r);
    endtask

    // Clock.
    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Word builders for the file generator.
    task automatic put_byte(logic [7:0] b);
        word_q.push_back('{b, 1'b0});
    endtask

    task automatic put_u32(logic [31:0] v);
        for (int k = 0; k < 4; k++) put_byte(v[8*k +: 8]);
    endtask

    task automatic end_file();
        t_word w;
        if (word_q.size() == 0) begin
            word_q.push_back('{8'h00, 1'b1});
        end else begin
            w = word_q.pop_back();
            w.last = 1;
            word_q.push_back(w);
        end
        n_files++;
    endtask

    task automatic put_fmt(logic [15:0] f, logic [15:0] ch, logic [31:0] rate,
                           logic [15:0] bits, int size);
        put_u32(TAG_FMT);
        put_u32(size);
        for (int k = 0; k < size + (size & 1); k++) begin
            case (k)
                0: put_byte(f[7:0]);
                1: put_byte(f[15:8]);
                2: put_byte(ch[7:0]);
                3: put_byte(ch[15:8]);
                4, 5, 6, 7: put_byte(rate[8*(k-4) +: 8]);
                14: put_byte(bits[7:0]);
                15: put_byte(bits[15:8]);
                default: put_byte(8'($urandom));
            endcase
        end
    endtask

    // Random channel word, biased toward edge values.
    function automatic logic [31:0] pick_raw();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'($urandom_range(100, 130)),
                       23'($urandom)};
            5: return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1))};
            default: return $urandom;
        endcase
    endfunction

    // One well formed file with random content; small frame counts.
    task automatic put_wave(logic [15:0] f, logic [15:0] ch, logic [15:0] bits,
                            int frames, int extra);
        int fb;
        logic [31:0] raw;
        fb = int'(bits >> 3);
        put_u32(TAG_RIFF);
        put_u32($urandom);
        put_u32(TAG_WAVE);
        if ($urandom_range(0, 2) == 0) begin
            put_u32(32'h5453_494C);
            put_u32(3);
            repeat (4) put_byte(8'($urandom));
        end
        put_fmt(f, ch, $urandom_range(0, 3) ? 32'd48000 : 32'h0100_0000, bits,
                $urandom_range(0, 3) ? 16 : 18);
        put_u32(TAG_DATA);
        put_u32(frames * fb * ch + extra);
        for (int i = 0; i < frames * ch; i++) begin
            raw = pick_raw();
            for (int k = 0; k < fb; k++) put_byte(k < 4 ? raw[8*k +: 8] : 8'($urandom));
        end
        repeat (extra) put_byte(8'($urandom));
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 5)) put_byte(8'($urandom));
        end_file();
    endtask

    function automatic logic [15:0] pick_bits();
        case ($urandom_range(0, 9))
            0, 1: return 16'd8;
            2, 3: return 16'd16;
            4, 5: return 16'd24;
            6, 7, 8: return 16'd32;
            default: return 16'($urandom_range(9, 40));
        endcase
    endfunction

    // Stimulus.
    initial begin
        int target;
        errors = 0; n_samples = 0; n_reports = 0; n_files = 0;
        stim_done = 0; hold_rx = 0; hold_tx = 0;
        i_rst_n = 0;
        clear_state();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: depths, float, many channels, bad tags, short fmt, sub-byte depth, early end.
        put_wave(16'd1, 16'd1, 16'd8, 2, 0);
        put_wave(16'd1, 16'd2, 16'd16, 2, 1);
        put_wave(FMT_FLOAT, 16'd2, 16'd32, 3, 0);
        put_wave(16'd1, 16'd3, 16'd24, 1, 0);
        put_wave(16'd1, 16'hFFFF, 16'd8, 0, 5);
        put_u32(32'h4646_4953); end_file();
        put_u32(TAG_RIFF); put_u32(0); put_u32(32'h0000_0000); end_file();
        put_u32(TAG_RIFF); put_u32(0); put_u32(TAG_WAVE);
        put_fmt(16'd1, 16'd1, 1, 16'd16, 14); put_u32(TAG_DATA); put_u32(4); end_file();
        put_u32(TAG_RIFF); put_u32(0); put_u32(TAG_WAVE);
        put_fmt(16'd1, 16'd1, 1, 16'd4, 16); put_u32(TAG_DATA); put_u32(4); end_file();
        put_u32(TAG_RIFF); put_byte(8'h12); end_file();
        put_u32(TAG_RIFF); put_u32(0); put_u32(TAG_WAVE); put_byte(8'h66); end_file();
        word_q.push_back('{8'hFF, 1'b1}); n_files++;

        // Random: mostly well formed files, some noise.
        target = 900;
        while (word_q.size() < target) begin
            if (word_q.size() > 450 && !hold_tx) begin
                wait (word_q.size() == 0);
                hold_tx = 1;
                wait (sample_q.size() == 0);
                repeat (60) @(posedge i_clk);
                hold_tx = 0;
                target -= 450;
            end
            case ($urandom_range(0, 9))
                0: begin
                    repeat ($urandom_range(1, 20)) put_byte(8'($urandom));
                    end_file();
                end
                1: begin
                    put_u32(TAG_RIFF); put_u32($urandom); put_u32(TAG_WAVE);
                    put_u32(TAG_DATA); put_u32(8); end_file();
                end
                2: put_wave(16'($urandom_range(1, 3)), 16'($urandom_range(1, 4)),
                            16'($urandom_range(1, 7)), 1, 0);
                default: put_wave(16'($urandom_range(0, 3)) == 0 ? FMT_FLOAT
                                  : 16'($urandom_range(1, 3)),
                                  16'($urandom_range(1, 4)), pick_bits(),
                                  $urandom_range(1, 6), $urandom_range(0, 2));
            endcase
        end
        wait (word_q.size() == 0);
        @(posedge i_clk);
        stim_done = 1;
    end

    // Sender: bursts and gaps.
    int tx_burst;
    int tx_gap;
    bit tx_taken;

    // Input handshake as seen by the block at the rising edge.
    always @(posedge i_clk) begin
        tx_taken <= i_valid && !o_stall;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!(i_valid && !tx_taken)) begin
            if (i_valid) begin
                if (tx_burst > 0) tx_burst = tx_burst - 1;
                if (tx_burst == 0) tx_gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            end
            if (tx_gap > 0 || hold_tx || word_q.size() == 0) begin
                if (tx_gap > 0) tx_gap = tx_gap - 1;
                if (tx_gap == 0 && tx_burst == 0) tx_burst = $urandom_range(1, 40);
                i_valid <= 0;
            end else begin
                if (tx_burst == 0) tx_burst = $urandom_range(1, 40);
                i_valid     <= 1;
                i_file_byte <= word_q[0].fbyte;
                i_last_byte <= word_q[0].last;
                decode_word(word_q.pop_front());
            end
        end
    end

    // Receiver stall pattern, with one long hold-off.
    int rx_cycle;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 0;
            rx_cycle <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= 2000 && rx_cycle < 2600) i_stall <= 1;
            else if ((rx_cycle / 300) % 3 == 2) i_stall <= 0;
            else i_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (sample_q.size() == 0) begin
                $error("unexpected result word kind=%0d sample=%h code=%0d",
                       o_result_kind, o_sample, o_error_code);
                errors++;
            end else begin
                w = sample_q.pop_front();
                if (o_result_kind !== w.kind) begin
                    $error("result_kind expected %0d actual %0d", w.kind, o_result_kind);
                    errors++;
                end
                if (o_sample !== w.smp) begin
                    $error("sample expected %h actual %h", w.smp, o_sample);
                    errors++;
                end
                if (o_error_code !== w.err) begin
                    $error("error_code expected %0d actual %0d", w.err, o_error_code);
                    errors++;
                end
                if (w.kind == KIND_SAMPLE) n_samples++;
                else n_reports++;
            end
        end
    end

    // Inputs known from time zero.
    initial begin
        i_valid = 0; i_file_byte = 0; i_last_byte = 0; i_stall = 0;
        tx_burst = 0; tx_gap = 0; tx_taken = 0;
    end

    // End of run.
    initial begin
        wait (stim_done);
        wait (sample_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (sample_q.size() != 0) errors++;
        $display("Decoded %0d files: %0d samples and %0d error reports checked.",
                 n_files, n_samples, n_reports);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    // Watchdog.
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule
